// ----- hdl/cmt_pkg.sv -----
`timescale 1ns / 1ps

package cmt_pkg;

   // Widths of the request and response fields.
   localparam int OPCODE_W     = 3;
   localparam int ITEM_W       = 32;
   localparam int INDEX_W      = 4;
   localparam int COUNT_OUT_W  = 16;
   localparam int VALUE_OUT_W  = 32;
   localparam int DISTINCT_W   = 5;
   localparam int TOTAL_W      = 20;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT    = 3'd0,
      OP_ERASE_ONE = 3'd1,
      OP_ERASE_ALL = 3'd2,
      OP_COUNT     = 3'd3,
      OP_GET       = 3'd4
   } opcode_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [ITEM_W-1:0]   item_value;
      logic [INDEX_W-1:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic                    ok;
      logic [COUNT_OUT_W-1:0]  count_out;
      logic [VALUE_OUT_W-1:0]  value_out;
      logic [DISTINCT_W-1:0]   distinct_entries;
      logic [TOTAL_W-1:0]      total_size;
      logic                    is_empty;
   } rsp_type;

endpackage

// ----- hdl/cmt_entry_ram.sv -----
`timescale 1ns / 1ps

// One write port and one read port; read data is registered.
module cmt_entry_ram #(
   parameter int DEPTH      = 16,
   parameter int ADDR_WIDTH = 4,
   parameter int WIDTH      = 48
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/counted_multiset_table_core.sv -----
`timescale 1ns / 1ps
// Unknown opcodes, gets out of range and lookups on an empty table answer in the cycle after
// the request; a valid get answers once the indexed entry has been read; a lookup answers once
// it hits or has scanned all used entries, and a removal that frees an entry then also shifts
// the later entries down. The single read port of the entry memory, one entry a cycle, paces both.
// A new request is taken only once the last one has answered; busy falls as the response issues.
// Reset clears the entry count, the total and the control state; the entry memory is not swept.
module counted_multiset_table_core #(
   parameter int TABLE_DEPTH = 16,
   parameter int VALUE_WIDTH = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  cmt_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_strobe,
   output cmt_pkg::rsp_type rsp_data
);

   import cmt_pkg::*;

   // Address width of the entry memory and width of the used-entry counter, which must also
   // hold TABLE_DEPTH itself.
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int UW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = VALUE_WIDTH + COUNT_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [UW-1:0] DEPTH_U = UW'(TABLE_DEPTH);

   // The sequencer. SCAN walks the table one entry per cycle looking for the key; SHIFT moves
   // later entries down by one to close the gap left by a removed entry; GET waits for the
   // memory read of an indexed entry.
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_GET   = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   opcode_type              op_ff, op_in;
   logic [VALUE_WIDTH-1:0]  key_ff, key_in;
   logic [AW-1:0]           ptr_ff, ptr_in;
   logic [UW-1:0]           used_ff, used_in;
   logic [TOTAL_W-1:0]      sum_ff, sum_in;
   logic                    hold_ok_ff, hold_ok_in;
   logic [COUNT_WIDTH-1:0]  hold_cnt_ff, hold_cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   // Entry memory ports. Each entry holds the value above its count.
   logic [AW-1:0]           rd_addr;
   logic [EW-1:0]           rd_q;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [EW-1:0]           wr_data;

   logic [63:0]             req_key_wide;
   logic [VALUE_WIDTH-1:0]  req_key;
   logic [31:0]             req_idx_wide;
   logic                    idx_in_range;
   logic [VALUE_WIDTH-1:0]  q_val;
   logic [COUNT_WIDTH-1:0]  q_cnt;
   logic [UW-1:0]           ptr_next_u;
   logic                    more_after;
   logic                    scan_hit;

   // Response fields before they are fitted to the port widths.
   logic                    done;
   logic                    miss;
   opcode_type              miss_op;
   logic [VALUE_WIDTH-1:0]  miss_key;
   logic                    r_ok;
   logic [COUNT_WIDTH-1:0]  r_cnt;
   logic [VALUE_WIDTH-1:0]  r_val;
   logic [31:0]             r_cnt_wide;
   logic [63:0]             r_val_wide;
   logic [31:0]             used_wide;
   logic [31:0]             q_cnt_wide;

   cmt_entry_ram #(
      .DEPTH      (TABLE_DEPTH),
      .ADDR_WIDTH (AW),
      .WIDTH      (EW)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_q)
   );

   // Only the low VALUE_WIDTH bits of the requested value take part in the comparison.
   assign req_key_wide = 64'(req_data.item_value);
   assign req_key      = req_key_wide[VALUE_WIDTH-1:0];
   assign req_idx_wide = 32'(req_data.entry_index);
   assign idx_in_range = req_idx_wide < 32'(used_ff);

   assign q_val      = rd_q[EW-1:COUNT_WIDTH];
   assign q_cnt      = rd_q[COUNT_WIDTH-1:0];
   assign q_cnt_wide = 32'(q_cnt);
   assign ptr_next_u = UW'(ptr_ff) + UW'(1);
   assign more_after = ptr_next_u < used_ff;
   assign scan_hit   = (q_val == key_ff);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      ptr_in   = ptr_ff;
      used_in  = used_ff;
      sum_in   = sum_ff;
      rd_addr  = '0;
      wr_en    = 1'b0;
      wr_addr  = ptr_ff;
      wr_data  = '0;
      done     = 1'b0;
      miss     = 1'b0;
      miss_op  = op_ff;
      miss_key = key_ff;
      r_ok     = 1'b0;
      r_cnt    = '0;
      r_val    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_data.opcode == OP_GET) begin
               rd_addr = AW'(req_idx_wide);
            end
            if (start) begin
               op_in    = req_data.opcode;
               key_in   = req_key;
               miss_op  = req_data.opcode;
               miss_key = req_key;
               ptr_in   = '0;
               case (req_data.opcode)
                  OP_INSERT, OP_ERASE_ONE, OP_ERASE_ALL, OP_COUNT: begin
                     // Entry 0 is being read now; an empty table is an immediate miss.
                     if (used_ff == '0) begin
                        miss = 1'b1;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_GET: begin
                     if (idx_in_range) begin
                        state_in = ST_GET;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // The entry at ptr is on the read port; the next one is fetched ahead.
            rd_addr = ptr_ff + AW'(1);
            if (scan_hit) begin
               case (op_ff)
                  OP_INSERT: begin
                     done = 1'b1;
                     if (q_cnt != COUNT_MAX) begin
                        wr_en   = 1'b1;
                        wr_data = {q_val, q_cnt + COUNT_WIDTH'(1)};
                        sum_in  = sum_ff + TOTAL_W'(1);
                        r_ok    = 1'b1;
                     end
                  end
                  OP_ERASE_ONE: begin
                     r_ok  = 1'b1;
                     r_cnt = COUNT_WIDTH'(1);
                     if (q_cnt > COUNT_WIDTH'(1)) begin
                        wr_en   = 1'b1;
                        wr_data = {q_val, q_cnt - COUNT_WIDTH'(1)};
                        sum_in  = sum_ff - TOTAL_W'(1);
                        done    = 1'b1;
                     end else begin
                        sum_in   = sum_ff - q_cnt_wide[TOTAL_W-1:0];
                        state_in = ST_SHIFT;
                     end
                  end
                  OP_ERASE_ALL: begin
                     r_ok     = 1'b1;
                     r_cnt    = q_cnt;
                     sum_in   = sum_ff - q_cnt_wide[TOTAL_W-1:0];
                     state_in = ST_SHIFT;
                  end
                  default: begin
                     r_ok  = 1'b1;
                     r_cnt = q_cnt;
                     done  = 1'b1;
                  end
               endcase
            end else if (more_after) begin
               ptr_in = ptr_ff + AW'(1);
            end else begin
               miss = 1'b1;
            end
         end

         ST_SHIFT: begin
            // The entry after ptr is on the read port and moves down into ptr.
            rd_addr = ptr_ff + AW'(2);
            r_ok    = hold_ok_ff;
            r_cnt   = hold_cnt_ff;
            wr_en   = 1'b1;
            if (more_after) begin
               wr_data = rd_q;
               ptr_in  = ptr_ff + AW'(1);
            end else begin
               // The freed last position is cleared.
               wr_data = '0;
               used_in = used_ff - UW'(1);
               done    = 1'b1;
            end
         end

         ST_GET: begin
            r_ok  = 1'b1;
            r_cnt = q_cnt;
            r_val = q_val;
            done  = 1'b1;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A lookup that found nothing. An insert then appends at the end if there is room.
      if (miss) begin
         done = 1'b1;
         if (miss_op == OP_INSERT && used_ff < DEPTH_U) begin
            wr_en   = 1'b1;
            wr_addr = AW'(used_ff);
            wr_data = {miss_key, COUNT_WIDTH'(1)};
            used_in = used_ff + UW'(1);
            sum_in  = sum_ff + TOTAL_W'(1);
            r_ok    = 1'b1;
         end
      end

      if (done) begin
         state_in = ST_IDLE;
      end
   end

   // The result of a removal is known at the hit and is carried through the shift.
   assign hold_ok_in  = (state_ff == ST_SHIFT) ? hold_ok_ff : r_ok;
   assign hold_cnt_in = (state_ff == ST_SHIFT) ? hold_cnt_ff : r_cnt;

   // The response reports the table as it stands after the request.
   assign r_cnt_wide = 32'(r_cnt);
   assign r_val_wide = 64'(r_val);
   assign used_wide  = 32'(used_in);

   always_comb begin
      rsp_in.ok               = r_ok;
      rsp_in.count_out        = r_cnt_wide[COUNT_OUT_W-1:0];
      rsp_in.value_out        = r_val_wide[VALUE_OUT_W-1:0];
      rsp_in.distinct_entries = used_wide[DISTINCT_W-1:0];
      rsp_in.total_size       = sum_in;
      rsp_in.is_empty         = (used_in == '0);
   end

   assign rsp_valid_in = done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      ptr_ff      <= ptr_in;
      hold_ok_ff  <= hold_ok_in;
      hold_cnt_ff <= hold_cnt_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   // The table never holds more entries than it has room for.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= DEPTH_U)
      else $error("used entry count exceeds table depth");

   // The number of distinct entries moves by at most one per request.
   a_used_step: assert property (@(posedge clock) disable iff (reset)
      (used_ff != $past(used_ff)) |->
         (used_ff == $past(used_ff) + UW'(1) || used_ff == $past(used_ff) - UW'(1)))
      else $error("used entry count jumped by more than one");

   // The shift only ever touches valid entries.
   a_shift_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (UW'(ptr_ff) < used_ff))
      else $error("shift pointer beyond the used entries");

   // A response follows either an accepted request or work in progress.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(start || state_ff != ST_IDLE))
      else $error("response without a request");
`endif

endmodule
